// ----- sv/fvts_pkg.sv -----
`timescale 1ns / 1ps
package fvts_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 16;
    localparam int KEY_W           = 32;
    localparam int CFG_W           = 16;
    localparam logic [CFG_W-1:0] TIMESLICE_RST = 16'd100;
    localparam logic [CFG_W-1:0] MIN_GRAN_RST  = 16'd50;

    typedef enum logic [1:0] {
        ACT_SCHEDULE   = 2'd0,
        ACT_SELECT     = 2'd1,
        ACT_RESCHEDULE = 2'd2,
        ACT_UNSCHEDULE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_RUN  = 2'd2,
        ST_UNUSED  = 2'd3
    } t_status;

    localparam logic CFG_TIMESLICE = 1'b0;
    localparam logic CFG_MIN_GRAN  = 1'b1;

    // Q16 inverse weight per priority
    function automatic logic [18:0] inv_weight(input logic [2:0] prio);
        logic [18:0] w;
        case (prio)
            3'd0:    w = 19'd13107;
            3'd1:    w = 19'd21845;
            3'd2:    w = 19'd32768;
            3'd3:    w = 19'd65536;
            3'd4:    w = 19'd109227;
            default: w = 19'd327680;
        endcase
        return w;
    endfunction
endpackage

// ----- sv/fvts_scan.sv -----
`timescale 1ns / 1ps
// Scan engine: walks the table one slot per cycle with one compare unit.
// Mode min: finds smallest valid key (optionally skipping one slot) and first free slot.
// Mode hit: reports whether a probe key is present.
module fvts_scan #(
    parameter int TABLE_DEPTH = 16,
    parameter int IW          = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic                        i_hit_mode,
    input  logic                        i_skip_en,
    input  logic [IW-1:0]               i_skip_idx,
    input  logic [fvts_pkg::KEY_W-1:0]  i_probe,
    input  logic                        i_slot_valid,
    input  logic [fvts_pkg::KEY_W-1:0]  i_slot_key,
    output logic [IW-1:0]               o_idx,
    output logic                        o_done,
    output logic                        o_found,
    output logic [IW-1:0]               o_best_idx,
    output logic [fvts_pkg::KEY_W-1:0]  o_best_key,
    output logic                        o_free_found,
    output logic [IW-1:0]               o_free_idx,
    output logic                        o_hit
);
    import fvts_pkg::*;

    logic              r_busy, n_busy;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_found, n_found;
    logic [IW-1:0]     r_best_idx, n_best_idx;
    logic [KEY_W-1:0]  r_best_key, n_best_key;
    logic              r_free_found, n_free_found;
    logic [IW-1:0]     r_free_idx, n_free_idx;
    logic              r_hit, n_hit;
    logic              r_done, n_done;
    logic              live;

    assign live = i_slot_valid && !(i_skip_en && r_idx == i_skip_idx);

    // advance one slot per cycle
    always_comb begin
        n_busy       = r_busy;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_key   = r_best_key;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_hit        = r_hit;
        n_done       = 1'b0;
        if (i_go) begin
            n_busy       = 1'b1;
            n_idx        = '0;
            n_found      = 1'b0;
            n_free_found = 1'b0;
            n_hit        = 1'b0;
        end else if (r_busy) begin
            if (i_hit_mode) begin
                if (i_slot_valid && i_slot_key == i_probe) n_hit = 1'b1;
            end else begin
                if (live && (!r_found || i_slot_key < r_best_key)) begin
                    n_found    = 1'b1;
                    n_best_idx = r_idx;
                    n_best_key = i_slot_key;
                end
                if (!i_slot_valid && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_idx;
                end
            end
            if (r_idx == IW'(TABLE_DEPTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_best_idx   <= n_best_idx;
        r_best_key   <= n_best_key;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_hit        <= n_hit;
    end

    assign o_idx        = r_idx;
    assign o_done       = r_done;
    assign o_found      = r_found;
    assign o_best_idx   = r_best_idx;
    assign o_best_key   = r_best_key;
    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;
    assign o_hit        = r_hit;
endmodule

// ----- sv/fair_virtual_time_scheduler.sv -----
`timescale 1ns / 1ps
// Fair virtual-time scheduler.
// Command channel: pulse i_start with i_action and its operands while o_busy is
// low; the transaction is taken at that edge. One result comes back on
// o_done for exactly one cycle with o_selected_valid, o_selected_pid,
// o_granted_runtime and o_status; the receiver cannot stall it.
// Configuration: i_cfg_we with i_cfg_idx (0 timeslice, 1 min_granularity) and
// i_cfg_data, taken at any edge; the user must write only while idle (not enforced).
// Sequencing: select, schedule and reschedule are built around one slot-scan
// engine that visits one table slot per cycle, a full table pass per scan.
// One command is in flight at a time.
//   unschedule, or reschedule with no running task: no scan;
//   select: two passes, one when the table holds no task; full table: one pass;
//   schedule: one min pass plus one pass per key probe,
//   so (collisions + 1) probe passes follow the min pass.
// Reschedule adds a two-slice 16-bit multiply for the advance.
// Reset (synchronous, i_rst_n low) empties the table, drops the running task,
// clears the insert offset and loads timeslice 100, min_granularity 50.
module fair_virtual_time_scheduler
    import fvts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_action,
    input  logic [15:0]          i_task_pid,
    input  logic [2:0]           i_priority_req,
    input  logic [31:0]          i_remaining_runtime,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_done,
    output logic                 o_selected_valid,
    output logic [15:0]          o_selected_pid,
    output logic [31:0]          o_granted_runtime,
    output logic [1:0]           o_status
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SCAN1  = 11'b00000000010,
        S_SCAN2  = 11'b00000000100,
        S_MUL    = 11'b00000001000,
        S_KEY    = 11'b00000010000,
        S_PROBE  = 11'b00000100000,
        S_WRITE  = 11'b00001000000,
        S_GRANT  = 11'b00010000000,
        S_DONE   = 11'b00100000000,
        S_SEL2   = 11'b01000000000,
        S_BASE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_timeslice, r_min_gran;

    // table
    logic              r_valid [TABLE_DEPTH];
    logic [KEY_W-1:0]  r_key   [TABLE_DEPTH];
    logic [PID_BITS-1:0] r_pid [TABLE_DEPTH];
    logic [2:0]        r_prio  [TABLE_DEPTH];

    // running task and offset
    logic              r_run_valid;
    logic [PID_BITS-1:0] r_run_pid;
    logic [2:0]        r_run_prio;
    logic [KEY_W-1:0]  r_run_key, r_run_grant, r_offset;

    // latched command
    t_action           r_act;
    logic [PID_BITS-1:0] r_cmd_pid;
    logic [2:0]        r_cmd_prio;

    // work registers
    logic [KEY_W-1:0]  r_base, r_probe, r_acc;
    logic [KEY_W-1:0]  r_used;
    logic [1:0]        r_mcnt;
    logic [IW-1:0]     r_free_idx, r_sel_idx;
    logic [KEY_W-1:0]  r_sel_key;

    // result
    logic              r_done, r_sv;
    logic [PID_BITS-1:0] r_opid;
    logic [KEY_W-1:0]  r_grant;
    t_status           r_status;

    // scan engine hookup
    logic              sc_go, sc_hit_mode, sc_skip;
    logic [IW-1:0]     sc_idx, sc_best_idx, sc_free_idx;
    logic              sc_done, sc_found, sc_free_found, sc_hit;
    logic [KEY_W-1:0]  sc_best_key;

    fvts_scan #(.TABLE_DEPTH(TABLE_DEPTH), .IW(IW)) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (sc_go),
        .i_hit_mode   (sc_hit_mode),
        .i_skip_en    (sc_skip),
        .i_skip_idx   (r_sel_idx),
        .i_probe      (r_probe),
        .i_slot_valid (r_valid[sc_idx]),
        .i_slot_key   (r_key[sc_idx]),
        .o_idx        (sc_idx),
        .o_done       (sc_done),
        .o_found      (sc_found),
        .o_best_idx   (sc_best_idx),
        .o_best_key   (sc_best_key),
        .o_free_found (sc_free_found),
        .o_free_idx   (sc_free_idx),
        .o_hit        (sc_hit)
    );

    assign sc_hit_mode = (r_state == S_PROBE);
    assign sc_skip     = (r_state == S_SCAN2);

    logic [34:0] prod;
    logic [15:0] slice;
    logic [KEY_W-1:0] gap;
    logic [KEY_W-1:0] new_key;
    assign slice   = (r_mcnt == 2'd0) ? r_used[15:0] : r_used[31:16];
    assign prod    = 35'(slice) * 35'(inv_weight(r_run_prio));
    assign gap     = sc_best_key - r_sel_key;
    assign new_key = r_base + KEY_W'(r_min_gran) + r_offset + KEY_W'(r_min_gran);

    always_comb begin
        n_state = r_state;
        sc_go   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_UNSCHEDULE) n_state = S_DONE;
                    else if ((i_action == ACT_RESCHEDULE) && !r_run_valid) n_state = S_DONE;
                    else begin
                        n_state = S_SCAN1;
                        sc_go   = 1'b1;
                    end
                end
            end
            S_SCAN1: begin
                if (sc_done) begin
                    if (r_act == ACT_SELECT) n_state = sc_found ? S_SEL2 : S_DONE;
                    else if (!sc_free_found) n_state = S_DONE;
                    else if (r_act == ACT_RESCHEDULE) n_state = S_MUL;
                    else n_state = S_BASE;
                end
            end
            S_SEL2: begin
                sc_go   = 1'b1;
                n_state = S_SCAN2;
            end
            S_SCAN2: if (sc_done) n_state = S_GRANT;
            S_GRANT: n_state = S_DONE;
            S_MUL:   if (r_mcnt == 2'd1) n_state = S_BASE;
            S_BASE:  n_state = S_KEY;
            S_KEY: begin
                sc_go   = 1'b1;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (sc_done) n_state = sc_hit ? S_KEY : S_WRITE;
            end
            S_WRITE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeslice <= TIMESLICE_RST;
            r_min_gran  <= MIN_GRAN_RST;
            r_run_valid <= 1'b0;
            r_run_pid   <= '0;
            r_run_prio  <= '0;
            r_run_key   <= '0;
            r_run_grant <= '0;
            r_offset    <= '0;
            r_done      <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++) r_valid[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            // write configuration
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TIMESLICE) r_timeslice <= i_cfg_data;
                else r_min_gran <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    r_act      <= t_action'(i_action);
                    r_cmd_pid  <= PID_BITS'(i_task_pid);
                    r_cmd_prio <= i_priority_req;
                    r_sv       <= 1'b0;
                    r_opid     <= '0;
                    r_grant    <= '0;
                    r_status   <= (i_start && !r_run_valid &&
                                   ((i_action == ACT_UNSCHEDULE) ||
                                    (i_action == ACT_RESCHEDULE))) ? ST_NO_RUN : ST_OK;
                    r_mcnt     <= 2'd0;
                    r_acc      <= '0;
                    if (i_start) begin
                        if ((i_action == ACT_UNSCHEDULE) && r_run_valid)
                            r_run_valid <= 1'b0;
                        if (i_action == ACT_SELECT) r_run_valid <= 1'b0;
                        r_used <= (r_run_grant >= i_remaining_runtime) ?
                                  r_run_grant - i_remaining_runtime : '0;
                    end
                end
                S_SCAN1: begin
                    if (sc_done) begin
                        r_free_idx <= sc_free_idx;
                        r_sel_idx  <= sc_best_idx;
                        r_sel_key  <= sc_best_key;
                        r_base     <= sc_found ? sc_best_key : '0;
                        if (r_act != ACT_SELECT && !sc_free_found) r_status <= ST_FULL;
                        if (r_act == ACT_SELECT && sc_found)
                            r_valid[sc_best_idx] <= 1'b0;
                    end
                end
                S_SCAN2: begin
                    if (sc_done) begin
                        if (!sc_found) r_grant <= KEY_W'(r_timeslice) * 32'd10;
                        else if (gap < KEY_W'(r_min_gran)) r_grant <= KEY_W'(r_min_gran);
                        else r_grant <= gap;
                    end
                end
                S_GRANT: begin
                    r_run_valid <= 1'b1;
                    r_run_pid   <= r_pid[r_sel_idx];
                    r_run_prio  <= r_prio[r_sel_idx];
                    r_run_key   <= r_sel_key;
                    r_run_grant <= r_grant;
                    r_sv        <= 1'b1;
                    r_opid      <= r_pid[r_sel_idx];
                end
                // two 16-bit slices: low part shifted down, high part added up
                S_MUL: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd0) r_acc <= KEY_W'(prod[34:16]);
                    else r_acc <= r_acc + prod[31:0];
                end
                S_BASE: begin
                    if (r_act == ACT_RESCHEDULE) begin
                        r_base     <= r_run_key + r_acc;
                        r_cmd_pid  <= r_run_pid;
                        r_cmd_prio <= r_run_prio;
                    end
                end
                S_KEY: begin
                    // first probe builds the key; later ones bump it
                    if (r_mcnt != 2'd3) begin
                        r_probe <= (r_act == ACT_RESCHEDULE) ?
                                   r_run_key + r_acc + KEY_W'(r_min_gran) + r_offset
                                   + KEY_W'(r_min_gran) : new_key;
                        r_mcnt  <= 2'd3;
                    end else begin
                        r_probe <= r_probe + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_valid[r_free_idx] <= 1'b1;
                    r_key[r_free_idx]   <= r_probe;
                    r_pid[r_free_idx]   <= r_cmd_pid;
                    r_prio[r_free_idx]  <= r_cmd_prio;
                    if (r_act == ACT_RESCHEDULE) begin
                        r_offset    <= '0;
                        r_run_valid <= 1'b0;
                    end else begin
                        r_offset <= r_offset + KEY_W'(r_min_gran);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy            = (r_state != S_IDLE);
    assign o_done            = r_done;
    assign o_selected_valid  = r_sv;
    assign o_selected_pid    = 16'(r_opid);
    assign o_granted_runtime = r_grant;
    assign o_status          = r_status;
endmodule
